>>> sv/dead_server_failure_tracker_macros.svh
// Assertion macros shared by the dead server failure tracker RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef DEAD_SERVER_FAILURE_TRACKER_MACROS_SVH
`define DEAD_SERVER_FAILURE_TRACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DSFT_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DSFT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

>>> sv/dsft_pkg.sv
// Package for the dead server failure tracker: request codes, widths, payload types.
// Depends on nothing.
package dsft_pkg;
  localparam int MaxEntriesDef = 16;
  localparam int KeyBitsDef    = 64;
  localparam int MsPerS        = 1000;

  typedef enum logic [2:0] {
    REQ_CHECK = 3'd0, REQ_FAIL = 3'd1, REQ_ALIVE = 3'd2,
    REQ_PRUNE = 3'd3, REQ_CLEAR = 3'd4, REQ_STATS = 3'd5
  } req_t;

  localparam logic [0:0] CFG_THRESHOLD = 1'b0;
  localparam logic [0:0] CFG_TTL       = 1'b1;
  localparam int CfgDataBits = 16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] server_key;
    logic [47:0] now_ms;
  } req_item_t;

  typedef struct packed {
    logic        is_dead;
    logic [15:0] ttl_remaining_s;
    logic [7:0]  failure_count;
    logic [47:0] marked_at_ms;
    logic [8:0]  pruned_count;
    logic [8:0]  live_dead_count;
    logic [8:0]  tracked_count;
    logic [31:0] check_total;
    logic [31:0] dead_hit_total;
    logic [31:0] alive_total;
    logic [31:0] dead_mark_total;
    logic [31:0] expiry_total;
  } rsp_item_t;

  // Status of one table entry after the expiry evaluation.
  typedef struct packed {
    logic expired;
    logic live_dead;
  } ent_stat_t;
endpackage

>>> sv/dsft_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface dsft_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/dsft_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module dsft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/dsft_expiry.sv
// Expiry evaluation of one registered table entry against now_ms and the TTL.
// Depends on dsft_pkg.
module dsft_expiry (
  input  logic                 clk,
  input  logic                 dead,
  input  logic [47:0]          marked,
  input  logic [47:0]          now_ms,
  input  logic [26:0]          ttl_ms,
  output dsft_pkg::ent_stat_t  stat,
  output logic [26:0]          left_ms
);
  import dsft_pkg::*;
  logic [48:0] age;
  logic        neg;
  always_comb begin
    age  = {1'b0, now_ms} - {1'b0, marked};
    neg  = age[48];
    stat.expired   = dead && !neg && (age[47:0] >= {21'd0, ttl_ms});
    stat.live_dead = dead && !stat.expired;
  end
  // Remaining milliseconds, registered before the divide by 1000.
  always_ff @(posedge clk) begin
    if (!dead || neg || stat.expired) begin
      left_ms <= '0;
    end else begin
      left_ms <= ttl_ms - age[26:0];
    end
  end
endmodule

>>> sv/dead_server_failure_tracker.sv
// Dead server failure tracker: one request in, one response out, one at a time.
// Each request walks the entry memory slot by slot through its single read port
// (S_SCAN_RD, S_SCAN_EV), then passes S_ACT and S_RESP; a check that hits a live dead
// mark also passes S_TTL and S_DIV, and clear and unknown requests skip the slot walk.
// The next request is taken in the cycle after the response is accepted. Reset (synchronous,
// active high) empties the table, zeroes the counters, loads threshold 3 and TTL 300 s.
`include "dead_server_failure_tracker_macros.svh"
module dead_server_failure_tracker #(
  parameter int MAX_ENTRIES = dsft_pkg::MaxEntriesDef,
  parameter int KEY_BITS    = dsft_pkg::KeyBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  dsft_if.sink                          req,
  dsft_if.source                        rsp,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [dsft_pkg::CfgDataBits-1:0] cfg_data
);
  import dsft_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = KEY_BITS + 8 + 1 + 48;
  // Reciprocal of 1000 scaled by 2^39; exact floor for every input below 2^27.
  localparam logic [29:0] Recip1000 = 30'd549755814;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [7:0]          fails;
    logic                dead;
    logic [47:0]         marked;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_ACT, S_MOVE_RD, S_MOVE_WR,
    S_TTL, S_DIV, S_RESP
  } state_t;

  // Configuration registers.
  logic [7:0]  fail_threshold;
  logic [15:0] dead_ttl_seconds;
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_threshold   <= 8'd3;
      dead_ttl_seconds <= 16'd300;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) begin
        fail_threshold <= cfg_data[7:0];
      end else begin
        dead_ttl_seconds <= cfg_data;
      end
    end
  end

  // TTL in ms, one multiply register (user keeps config stable while busy; not enforced).
  logic [26:0] ttl_ms;
  always_ff @(posedge clk) begin
    ttl_ms <= 27'(dead_ttl_seconds) * 27'(MsPerS);
  end

  state_t              state;
  req_t                cur_req;
  logic [2:0]          cur_raw;
  logic [KEY_BITS-1:0] cur_key;
  logic [47:0]         cur_now;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;        // slot being scanned
  logic [CW-1:0]       wr_ptr;     // compaction write slot for prune/remove
  logic                found;
  logic [AW-1:0]       hit_slot;
  ent_t                hit_ent;
  logic [31:0]         c_check, c_hit, c_alive, c_mark, c_exp;
  logic [8:0]          pruned, cur_dead;
  logic [26:0]         left_hold;
  logic [15:0]         ttl_q;
  rsp_item_t           out_item;
  logic                out_valid;

  // Entry memory.
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  ent_t          m_wdata, m_rdata;
  logic [EW-1:0] m_rbits;

  dsft_ram #(.Width(EW), .Depth(MAX_ENTRIES)) u_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rbits)
  );
  assign m_rdata = ent_t'(m_rbits);

  ent_stat_t   ev;
  logic [26:0] left_ms;
  dsft_expiry u_exp (
    .clk(clk), .dead(m_rdata.dead), .marked(m_rdata.marked), .now_ms(cur_now),
    .ttl_ms(ttl_ms), .stat(ev), .left_ms(left_ms)
  );

  logic key_eq;
  assign key_eq = (m_rdata.key == cur_key);

  // Removal decision for the entry just read in the scan.
  logic drop;
  always_comb begin
    unique case (cur_req)
      REQ_PRUNE: drop = ev.expired;
      REQ_ALIVE: drop = key_eq && !found;
      REQ_CHECK: drop = key_eq && !found && ev.expired;
      default:   drop = 1'b0;
    endcase
  end

  logic [7:0] thr;
  assign thr = (fail_threshold == 8'd0) ? 8'd1 : fail_threshold;

  // Memory control: the read address follows the scan index; writes occur in
  // compaction (survivors shift down) and in the failure update.
  ent_t upd;
  always_comb begin
    m_raddr = idx[AW-1:0];
    m_we    = 1'b0;
    m_waddr = wr_ptr[AW-1:0];
    m_wdata = m_rdata;
    upd     = hit_ent;
    if (found) begin
      if (hit_ent.fails != 8'hFF) upd.fails = hit_ent.fails + 8'd1;
    end else begin
      upd.key = cur_key; upd.fails = 8'd1; upd.dead = 1'b0; upd.marked = '0;
    end
    if (upd.fails >= thr && !upd.dead) begin
      upd.dead = 1'b1; upd.marked = cur_now;
    end
    if (state == S_SCAN_EV && !drop && (wr_ptr != idx) &&
        (cur_req == REQ_PRUNE || cur_req == REQ_ALIVE || cur_req == REQ_CHECK)) begin
      m_we = 1'b1;
    end
    if (state == S_ACT && cur_req == REQ_FAIL && (found || count < CW'(MAX_ENTRIES))) begin
      m_we    = 1'b1;
      m_waddr = found ? hit_slot : count[AW-1:0];
      m_wdata = upd;
    end
  end

  // Quotient of remaining ms by 1000 via reciprocal: floor(x*Recip1000 >> 39).
  logic [15:0] q_est;
  logic [56:0] prod;
  assign prod  = {30'd0, left_hold} * {27'd0, Recip1000};
  assign q_est = prod[54:39];

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; out_valid <= 1'b0;
      c_check <= '0; c_hit <= '0; c_alive <= '0; c_mark <= '0; c_exp <= '0;
      idx <= '0; wr_ptr <= '0; found <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur_raw <= req.data.req_type;
            cur_req <= req_t'(req.data.req_type);
            cur_key <= req.data.server_key[KEY_BITS-1:0];
            cur_now <= req.data.now_ms;
            idx <= '0; wr_ptr <= '0; found <= 1'b0;
            pruned <= '0; cur_dead <= '0; left_hold <= '0;
            hit_slot <= '0;
            out_item <= '0;
            if (req.data.req_type == REQ_CHECK) c_check <= c_check + 32'd1;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx == count || cur_raw == REQ_CLEAR || cur_raw > REQ_STATS) begin
            state <= S_ACT;
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (key_eq && !found) begin
            found <= 1'b1; hit_slot <= idx[AW-1:0]; hit_ent <= m_rdata;
          end
          if (cur_req == REQ_STATS && ev.live_dead) cur_dead <= cur_dead + 9'd1;
          if (drop) begin
            if (cur_req == REQ_PRUNE) pruned <= pruned + 9'd1;
            if (cur_req == REQ_ALIVE) c_alive <= c_alive + 32'd1;
            else c_exp <= c_exp + 32'd1;
          end else begin
            wr_ptr <= wr_ptr + CW'(1);
          end
          if (cur_req == REQ_CHECK && key_eq && !found && ev.live_dead) begin
            c_hit <= c_hit + 32'd1;
            out_item.is_dead <= 1'b1;
            out_item.failure_count <= m_rdata.fails;
            out_item.marked_at_ms <= m_rdata.marked;
            state <= S_TTL;
          end else begin
            state <= S_SCAN_RD;
          end
          idx <= idx + CW'(1);
        end
        S_TTL: begin
          // A live hit removes nothing, so every entry stays in the table.
          left_hold <= left_ms;
          idx <= count;
          wr_ptr <= count;
          state <= S_DIV;
        end
        S_DIV: begin
          ttl_q <= q_est;
          state <= S_SCAN_RD;
        end
        S_ACT: begin
          if (cur_req == REQ_CLEAR && cur_raw == REQ_CLEAR) begin
            count <= '0;
          end else if (cur_raw == REQ_FAIL) begin
            if (!found && count < CW'(MAX_ENTRIES)) count <= count + CW'(1);
            if ((found || count < CW'(MAX_ENTRIES)) && upd.dead && !(found && hit_ent.dead))
              c_mark <= c_mark + 32'd1;
          end else if (cur_raw == REQ_PRUNE || cur_raw == REQ_ALIVE ||
                       cur_raw == REQ_CHECK) begin
            count <= wr_ptr;
          end
          state <= S_RESP;
        end
        default: begin
          out_item.ttl_remaining_s <= out_item.is_dead ? ttl_q : 16'd0;
          out_item.pruned_count    <= pruned;
          out_item.live_dead_count <= cur_dead;
          out_item.tracked_count   <= 9'(count);
          out_item.check_total     <= c_check;
          out_item.dead_hit_total  <= c_hit;
          out_item.alive_total     <= c_alive;
          out_item.dead_mark_total <= c_mark;
          out_item.expiry_total    <= c_exp;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DSFT_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES), "count over depth")
  `DSFT_ASSERT_IMP(a_wr_behind, clk, rst, state == S_SCAN_EV, wr_ptr <= idx, "compaction ahead")
  `DSFT_ASSERT_NEXT(a_one_rsp, clk, rst, rsp.valid && !rsp.ready, rsp.valid, "response lost")
endmodule
